### rtl/tftp_rr_pkg.sv
package tftp_rr_pkg;

    localparam int BLOCK_BYTES_DEF = 512;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [15:0] OPCODE_DATA  = 16'd3;
    localparam logic [15:0] OPCODE_ACK   = 16'd4;
    localparam logic [15:0] OPCODE_ERROR = 16'd5;

    localparam logic [1:0] CMD_START  = 2'd0;
    localparam logic [1:0] CMD_PACKET = 2'd1;
    localparam logic [1:0] CMD_TICK   = 2'd2;

    localparam logic [0:0] REG_BUFFER_LIMIT  = 1'd0;
    localparam logic [0:0] REG_TIMEOUT_TICKS = 1'd1;

    localparam logic [23:0] BUFFER_LIMIT_RST  = 24'd65536;
    localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd1000;
    localparam logic [15:0] FIRST_PORT        = 16'd49152;
    localparam logic [15:0] WELL_KNOWN_PORT   = 16'd69;
    localparam logic [9:0]  HEADER_BYTES      = 10'd4;

    // what the back end has to do with a queued item
    typedef enum logic [2:0] {
        KIND_NONE  = 3'd0,
        KIND_START = 3'd1,
        KIND_TICK  = 3'd2,
        KIND_ERROR = 3'd3,
        KIND_DATA  = 3'd4
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] block_number;
        logic [31:0] source_ip;
        logic [15:0] source_port;
        logic [9:0]  pay_len;
        logic        short_blk;
    } entry_t;

endpackage

### rtl/tftp_read_receiver.sv
// tftp read receiver: receive side of a read-only tftp transfer
// a front classifier feeds a small queue (QUEUE_DEPTH entries) that a back end drains
// throughput: one beat per cycle in while the queue has room; the back end executes
//   one item per cycle while its result register is not stalled by m_ready
// reset: aresetn synchronous active low; resets transfer state and port counter,
//   clears queue pointers and result valid; config returns to its defaults
module tftp_read_receiver #(
    parameter int BLOCK_BYTES = tftp_rr_pkg::BLOCK_BYTES_DEF,
    parameter int QUEUE_DEPTH = tftp_rr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // config write port
    input  logic        cfg_wr_en,
    input  logic [0:0]  cfg_index,
    input  logic [23:0] cfg_wdata,
    // input items
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_cmd,
    input  logic [15:0] s_opcode,
    input  logic [15:0] s_block_number,
    input  logic [31:0] s_source_ip,
    input  logic [15:0] s_source_port,
    input  logic [9:0]  s_packet_length,
    // results
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic        m_ack_valid,
    output logic [15:0] m_ack_block,
    output logic [31:0] m_ack_dest_ip,
    output logic [15:0] m_ack_dest_port,
    output logic [15:0] m_local_port,
    output logic        m_write_valid,
    output logic [23:0] m_write_offset,
    output logic [9:0]  m_write_length,
    output logic [23:0] m_bytes_received
);
    import tftp_rr_pkg::*;

    localparam int EW = $bits(entry_t);

    entry_t          push_entry;
    entry_t          head_entry;
    logic [EW-1:0]   head_bits;
    logic            q_push;
    logic            q_pop;
    logic            q_full;
    logic            q_not_empty;

    // front: takes each beat and sorts it into start, tick, error, data or nothing
    tftp_rr_front #(
        .BLOCK_BYTES(BLOCK_BYTES)
    ) u_front (
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_cmd           (s_cmd),
        .s_opcode        (s_opcode),
        .s_block_number  (s_block_number),
        .s_source_ip     (s_source_ip),
        .s_source_port   (s_source_port),
        .s_packet_length (s_packet_length),
        .q_full          (q_full),
        .q_push          (q_push),
        .q_entry         (push_entry)
    );

    // queue between the two halves, so a stalled result stalls input only once it is full
    tftp_rr_fifo #(
        .WIDTH(EW),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (push_entry),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (head_bits),
        .not_empty (q_not_empty)
    );

    assign head_entry = entry_t'(head_bits);

    // back: transfer state, lock, block sequencing, overflow and timeout checks
    tftp_rr_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .q_not_empty      (q_not_empty),
        .q_entry          (head_entry),
        .q_pop            (q_pop),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_ack_valid      (m_ack_valid),
        .m_ack_block      (m_ack_block),
        .m_ack_dest_ip    (m_ack_dest_ip),
        .m_ack_dest_port  (m_ack_dest_port),
        .m_local_port     (m_local_port),
        .m_write_valid    (m_write_valid),
        .m_write_offset   (m_write_offset),
        .m_write_length   (m_write_length),
        .m_bytes_received (m_bytes_received)
    );

endmodule

### rtl/tftp_rr_front.sv
module tftp_rr_front #(
    parameter int BLOCK_BYTES = tftp_rr_pkg::BLOCK_BYTES_DEF
) (
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [1:0]           s_cmd,
    input  logic [15:0]          s_opcode,
    input  logic [15:0]          s_block_number,
    input  logic [31:0]          s_source_ip,
    input  logic [15:0]          s_source_port,
    input  logic [9:0]           s_packet_length,
    input  logic                 q_full,
    output logic                 q_push,
    output tftp_rr_pkg::entry_t  q_entry
);
    import tftp_rr_pkg::*;

    logic [9:0] dlen;

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;
    assign dlen    = s_packet_length - HEADER_BYTES;

    always_comb begin
        q_entry.block_number = s_block_number;
        q_entry.source_ip    = s_source_ip;
        q_entry.source_port  = s_source_port;
        q_entry.pay_len      = dlen;
        q_entry.short_blk    = ({22'd0, dlen} < 32'(BLOCK_BYTES));
        q_entry.kind         = KIND_NONE;
        case (s_cmd)
            CMD_START: begin
                q_entry.kind = KIND_START;
            end
            CMD_TICK: begin
                q_entry.kind = KIND_TICK;
            end
            CMD_PACKET: begin
                // runt packets and opcodes other than data or error do nothing
                if (s_packet_length >= HEADER_BYTES) begin
                    if (s_opcode == OPCODE_ERROR) begin
                        q_entry.kind = KIND_ERROR;
                    end else if (s_opcode == OPCODE_DATA) begin
                        q_entry.kind = KIND_DATA;
                    end
                end
            end
            default: begin
                q_entry.kind = KIND_NONE;
            end
        endcase
    end

endmodule

### rtl/tftp_rr_fifo.sv
module tftp_rr_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = tftp_rr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             not_empty
);
    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW:0]      wr_ptr_reg, wr_ptr_next;
    logic [AW:0]      rd_ptr_reg, rd_ptr_next;

    assign full      = (wr_ptr_reg[AW] != rd_ptr_reg[AW]) &&
                       (wr_ptr_reg[AW-1:0] == rd_ptr_reg[AW-1:0]);
    assign not_empty = (wr_ptr_reg != rd_ptr_reg);
    assign pop_data  = mem_reg[rd_ptr_reg[AW-1:0]];

    assign wr_ptr_next = wr_ptr_reg + (AW+1)'(push && !full);
    assign rd_ptr_next = rd_ptr_reg + (AW+1)'(pop && not_empty);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push && !full) begin
            mem_reg[wr_ptr_reg[AW-1:0]] <= push_data;
        end
    end

endmodule

### rtl/tftp_rr_back.sv
module tftp_rr_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [0:0]           cfg_index,
    input  logic [23:0]          cfg_wdata,
    input  logic                 q_not_empty,
    input  tftp_rr_pkg::entry_t  q_entry,
    output logic                 q_pop,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [1:0]           m_status,
    output logic                 m_ack_valid,
    output logic [15:0]          m_ack_block,
    output logic [31:0]          m_ack_dest_ip,
    output logic [15:0]          m_ack_dest_port,
    output logic [15:0]          m_local_port,
    output logic                 m_write_valid,
    output logic [23:0]          m_write_offset,
    output logic [9:0]           m_write_length,
    output logic [23:0]          m_bytes_received
);
    import tftp_rr_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_RUN  = 2'd1,
        PH_DONE = 2'd2,
        PH_ERR  = 2'd3
    } phase_t;

    logic [23:0] buffer_limit_reg;
    logic [15:0] timeout_ticks_reg;

    phase_t      phase_reg, phase_next;
    logic [15:0] expected_block_reg, expected_block_next;
    logic        locked_reg, locked_next;
    logic [15:0] peer_port_reg, peer_port_next;
    logic [23:0] total_bytes_reg, total_bytes_next;
    logic [15:0] elapsed_ticks_reg, elapsed_ticks_next;
    logic [15:0] next_port_reg, next_port_next;
    logic [15:0] current_port_reg, current_port_next;

    logic        m_valid_reg, m_valid_next;
    logic        ack_valid_reg, ack_valid_next;
    logic [15:0] ack_block_reg, ack_block_next;
    logic [31:0] ack_ip_reg, ack_ip_next;
    logic [15:0] ack_port_reg, ack_port_next;
    logic        wr_valid_reg, wr_valid_next;
    logic [23:0] wr_off_reg, wr_off_next;
    logic [9:0]  wr_len_reg, wr_len_next;

    logic        take;
    logic        accept;
    logic [24:0] sum;
    logic        overflow;
    logic [15:0] port_inc;
    logic [15:0] prev_block;

    assign take       = q_not_empty && (!m_valid_reg || m_ready);
    assign q_pop      = take;
    assign sum        = {1'b0, total_bytes_reg} + {15'd0, q_entry.pay_len};
    assign overflow   = sum > {1'b0, buffer_limit_reg};
    assign port_inc   = next_port_reg + 16'd1;
    assign prev_block = expected_block_reg - 16'd1;
    assign accept     = !locked_reg || (q_entry.source_port == peer_port_reg);

    always_comb begin
        phase_next          = phase_reg;
        expected_block_next = expected_block_reg;
        locked_next         = locked_reg;
        peer_port_next      = peer_port_reg;
        total_bytes_next    = total_bytes_reg;
        elapsed_ticks_next  = elapsed_ticks_reg;
        next_port_next      = next_port_reg;
        current_port_next   = current_port_reg;
        ack_valid_next      = 1'b0;
        ack_block_next      = '0;
        ack_ip_next         = '0;
        ack_port_next       = '0;
        wr_valid_next       = 1'b0;
        wr_off_next         = '0;
        wr_len_next         = '0;
        m_valid_next        = take || (m_valid_reg && !m_ready);

        if (take) begin
            case (q_entry.kind)
                KIND_START: begin
                    current_port_next   = next_port_reg;
                    next_port_next      = (port_inc == 16'd0) ? FIRST_PORT : port_inc;
                    expected_block_next = 16'd1;
                    locked_next         = 1'b0;
                    peer_port_next      = WELL_KNOWN_PORT;
                    total_bytes_next    = '0;
                    elapsed_ticks_next  = '0;
                    phase_next          = PH_RUN;
                end
                KIND_TICK: begin
                    if (phase_reg == PH_RUN) begin
                        if (elapsed_ticks_reg >= timeout_ticks_reg) begin
                            phase_next = PH_ERR;
                        end else begin
                            elapsed_ticks_next = elapsed_ticks_reg + 16'd1;
                        end
                    end
                end
                KIND_ERROR: begin
                    if (phase_reg == PH_RUN) begin
                        phase_next = PH_ERR;
                    end
                end
                KIND_DATA: begin
                    if (phase_reg == PH_RUN) begin
                        if (!locked_reg) begin
                            locked_next    = 1'b1;
                            peer_port_next = q_entry.source_port;
                        end
                        if (accept) begin
                            if (q_entry.block_number == expected_block_reg) begin
                                if (overflow) begin
                                    phase_next = PH_ERR;
                                end else begin
                                    wr_valid_next    = 1'b1;
                                    wr_off_next      = total_bytes_reg;
                                    wr_len_next      = q_entry.pay_len;
                                    total_bytes_next = sum[23:0];
                                    ack_valid_next   = 1'b1;
                                    ack_block_next   = q_entry.block_number;
                                    ack_ip_next      = q_entry.source_ip;
                                    ack_port_next    = q_entry.source_port;
                                    if (q_entry.short_blk) begin
                                        phase_next = PH_DONE;
                                    end else begin
                                        expected_block_next = expected_block_reg + 16'd1;
                                    end
                                end
                            end else if (q_entry.block_number == prev_block) begin
                                // duplicate of the last block, ack it again
                                ack_valid_next = 1'b1;
                                ack_block_next = q_entry.block_number;
                                ack_ip_next    = q_entry.source_ip;
                                ack_port_next  = q_entry.source_port;
                            end
                        end
                    end
                end
                default: begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buffer_limit_reg   <= BUFFER_LIMIT_RST;
            timeout_ticks_reg  <= TIMEOUT_TICKS_RST;
            phase_reg          <= PH_IDLE;
            expected_block_reg <= 16'd1;
            locked_reg         <= 1'b0;
            peer_port_reg      <= WELL_KNOWN_PORT;
            total_bytes_reg    <= '0;
            elapsed_ticks_reg  <= '0;
            next_port_reg      <= FIRST_PORT;
            current_port_reg   <= '0;
            m_valid_reg        <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_BUFFER_LIMIT: begin
                        buffer_limit_reg <= cfg_wdata;
                    end
                    REG_TIMEOUT_TICKS: begin
                        timeout_ticks_reg <= cfg_wdata[15:0];
                    end
                    default: begin
                        buffer_limit_reg <= buffer_limit_reg;
                    end
                endcase
            end
            phase_reg          <= phase_next;
            expected_block_reg <= expected_block_next;
            locked_reg         <= locked_next;
            peer_port_reg      <= peer_port_next;
            total_bytes_reg    <= total_bytes_next;
            elapsed_ticks_reg  <= elapsed_ticks_next;
            next_port_reg      <= next_port_next;
            current_port_reg   <= current_port_next;
            m_valid_reg        <= m_valid_next;
        end
    end

    // result payload, loaded when a queued item is executed
    always_ff @(posedge aclk) begin
        if (take) begin
            ack_valid_reg <= ack_valid_next;
            ack_block_reg <= ack_block_next;
            ack_ip_reg    <= ack_ip_next;
            ack_port_reg  <= ack_port_next;
            wr_valid_reg  <= wr_valid_next;
            wr_off_reg    <= wr_off_next;
            wr_len_reg    <= wr_len_next;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_status         = phase_reg;
    assign m_ack_valid      = ack_valid_reg;
    assign m_ack_block      = ack_block_reg;
    assign m_ack_dest_ip    = ack_ip_reg;
    assign m_ack_dest_port  = ack_port_reg;
    assign m_local_port     = current_port_reg;
    assign m_write_valid    = wr_valid_reg;
    assign m_write_offset   = wr_off_reg;
    assign m_write_length   = wr_len_reg;
    assign m_bytes_received = total_bytes_reg;

endmodule

### rtl/tftp_rr_checker.sv
module tftp_rr_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [1:0]  m_status,
    input logic        m_ack_valid,
    input logic [15:0] m_ack_block,
    input logic [31:0] m_ack_dest_ip,
    input logic [15:0] m_ack_dest_port,
    input logic        m_write_valid,
    input logic [23:0] m_write_offset,
    input logic [9:0]  m_write_length,
    input logic [23:0] m_bytes_received
);

    // stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) &&
            $stable(m_bytes_received) && $stable(m_ack_block))
        else $error("result beat changed while stalled");

    // no ack means zeroed ack fields
    a_ack_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ack_valid |->
            m_ack_block == 16'd0 && m_ack_dest_ip == 32'd0 && m_ack_dest_port == 16'd0)
        else $error("ack fields set without ack");

    // no write means zeroed write fields
    a_wr_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_write_valid |-> m_write_offset == 24'd0 && m_write_length == 10'd0)
        else $error("write fields set without write");

    // a write always comes with its ack and moves the byte count by its length
    a_wr_total: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_write_valid |-> m_ack_valid &&
            m_bytes_received == m_write_offset + {14'd0, m_write_length})
        else $error("write not matched by ack or byte count");

endmodule

bind tftp_read_receiver tftp_rr_checker u_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_status         (m_status),
    .m_ack_valid      (m_ack_valid),
    .m_ack_block      (m_ack_block),
    .m_ack_dest_ip    (m_ack_dest_ip),
    .m_ack_dest_port  (m_ack_dest_port),
    .m_write_valid    (m_write_valid),
    .m_write_offset   (m_write_offset),
    .m_write_length   (m_write_length),
    .m_bytes_received (m_bytes_received)
);

### dv/tftp_read_receiver_tb.sv
`timescale 1ns / 100ps

// self-checking bench for the tftp read receiver
// a beat-level model of the transfer state predicts one result beat per input beat;
// results are compared field by field in arrival order
module tftp_read_receiver_tb;
    import tftp_rr_pkg::*;

    // command code the block must ignore
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    // header plus one full data block
    localparam logic [9:0] FULL_PACKET = 10'(BLOCK_BYTES_DEF) + HEADER_BYTES;
    // largest payload the bench sends, from a 600-byte packet
    localparam int MAX_PAYLOAD = 596;
    localparam int MAX_REPORTS = 10;
    localparam logic [31:0] PEER_IP = 32'hC0A8_0A05;
    localparam logic [15:0] PEER_PORT = 16'd3071;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_BUSY  = 2'd1,
        ST_DONE  = 2'd2,
        ST_ERROR = 2'd3
    } xfer_status_t;

    // one input beat
    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] opcode;
        logic [15:0] block_number;
        logic [31:0] source_ip;
        logic [15:0] source_port;
        logic [9:0]  packet_length;
    } pkt_item_t;

    // one result beat
    typedef struct packed {
        logic [1:0]  status;
        logic        ack_valid;
        logic [15:0] ack_block;
        logic [31:0] ack_dest_ip;
        logic [15:0] ack_dest_port;
        logic [15:0] local_port;
        logic        write_valid;
        logic [23:0] write_offset;
        logic [9:0]  write_length;
        logic [23:0] bytes_received;
    } rx_result_t;

    // clock, reset and dut ports; every input starts at a known value
    logic        aclk;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [0:0]  cfg_index = '0;
    logic [23:0] cfg_wdata = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_cmd = '0;
    logic [15:0] s_opcode = '0;
    logic [15:0] s_block_number = '0;
    logic [31:0] s_source_ip = '0;
    logic [15:0] s_source_port = '0;
    logic [9:0]  s_packet_length = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_status;
    logic        m_ack_valid;
    logic [15:0] m_ack_block;
    logic [31:0] m_ack_dest_ip;
    logic [15:0] m_ack_dest_port;
    logic [15:0] m_local_port;
    logic        m_write_valid;
    logic [23:0] m_write_offset;
    logic [9:0]  m_write_length;
    logic [23:0] m_bytes_received;

    // idle knobs, in percent of cycles
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    // bookkeeping
    int items_sent = 0;
    int results_seen = 0;
    int mismatches = 0;
    int strays = 0;

    // expected result beats, oldest first
    rx_result_t pending_results[$];

    // predicted register values
    logic [23:0] cfg_buffer_limit;
    logic [15:0] cfg_timeout;

    // predicted transfer state
    xfer_status_t xfer_phase;
    logic [15:0]  xfer_expected;
    bit           xfer_locked;
    logic [15:0]  xfer_peer_port;
    logic [23:0]  xfer_total;
    logic [15:0]  xfer_ticks;
    logic [15:0]  port_counter;
    logic [15:0]  xfer_port;

    pkt_item_t  offered;
    rx_result_t observed;

    assign offered = {s_cmd, s_opcode, s_block_number, s_source_ip, s_source_port,
                      s_packet_length};
    assign observed = {m_status, m_ack_valid, m_ack_block, m_ack_dest_ip, m_ack_dest_port,
                       m_local_port, m_write_valid, m_write_offset, m_write_length,
                       m_bytes_received};

    tftp_read_receiver DUT (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_cmd            (s_cmd),
        .s_opcode         (s_opcode),
        .s_block_number   (s_block_number),
        .s_source_ip      (s_source_ip),
        .s_source_port    (s_source_port),
        .s_packet_length  (s_packet_length),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_ack_valid      (m_ack_valid),
        .m_ack_block      (m_ack_block),
        .m_ack_dest_ip    (m_ack_dest_ip),
        .m_ack_dest_port  (m_ack_dest_port),
        .m_local_port     (m_local_port),
        .m_write_valid    (m_write_valid),
        .m_write_offset   (m_write_offset),
        .m_write_length   (m_write_length),
        .m_bytes_received (m_bytes_received)
    );

    // 100 MHz clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // hard stop in case a beat never shows up
    initial begin
        #(10_000_000);
        $display("simulation failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // transfer model
    // ------------------------------------------------------------------

    // state after reset, registers at their defaults
    function automatic void model_reset();
        cfg_buffer_limit = BUFFER_LIMIT_RST;
        cfg_timeout      = TIMEOUT_TICKS_RST;
        xfer_phase       = ST_IDLE;
        xfer_expected    = 16'd1;
        xfer_locked      = 1'b0;
        xfer_peer_port   = WELL_KNOWN_PORT;
        xfer_total       = '0;
        xfer_ticks       = '0;
        port_counter     = FIRST_PORT;
        xfer_port        = '0;
    endfunction

    // advance the transfer state by one input beat and return the result beat
    function automatic rx_result_t next_transfer_result(input pkt_item_t it);
        rx_result_t  r;
        logic [9:0]  payload;
        logic [24:0] new_total;
        logic [15:0] prev_block;
        bit          take;
        r          = '0;
        payload    = it.packet_length - HEADER_BYTES;
        new_total  = {1'b0, xfer_total} + 25'(payload);
        prev_block = xfer_expected - 16'd1;
        take       = 1'b1;
        case (it.cmd)
            CMD_START: begin
                // new ephemeral port, zero is skipped by jumping back to the first one
                xfer_port    = port_counter;
                port_counter = port_counter + 16'd1;
                if (port_counter == 16'd0)
                    port_counter = FIRST_PORT;
                xfer_expected    = 16'd1;
                xfer_locked      = 1'b0;
                xfer_peer_port   = WELL_KNOWN_PORT;
                xfer_total       = '0;
                xfer_ticks       = '0;
                xfer_phase       = ST_BUSY;
            end
            CMD_TICK: begin
                if (xfer_phase == ST_BUSY) begin
                    if (xfer_ticks >= cfg_timeout)
                        xfer_phase = ST_ERROR;
                    else
                        xfer_ticks = xfer_ticks + 16'd1;
                end
            end
            CMD_PACKET: begin
                if (xfer_phase == ST_BUSY && it.packet_length >= HEADER_BYTES) begin
                    if (it.opcode == OPCODE_ERROR) begin
                        xfer_phase = ST_ERROR;
                    end else if (it.opcode == OPCODE_DATA) begin
                        // first data packet picks the server port, even if its block is dropped
                        if (!xfer_locked) begin
                            xfer_peer_port = it.source_port;
                            xfer_locked    = 1'b1;
                        end else if (it.source_port != xfer_peer_port) begin
                            take = 1'b0;
                        end
                        if (take && it.block_number == xfer_expected) begin
                            if (new_total > 25'(cfg_buffer_limit)) begin
                                xfer_phase = ST_ERROR;
                            end else begin
                                r.write_valid   = 1'b1;
                                r.write_offset  = xfer_total;
                                r.write_length  = payload;
                                xfer_total      = new_total[23:0];
                                r.ack_valid     = 1'b1;
                                r.ack_block     = it.block_number;
                                r.ack_dest_ip   = it.source_ip;
                                r.ack_dest_port = xfer_peer_port;
                                if (int'(payload) < BLOCK_BYTES_DEF)
                                    xfer_phase = ST_DONE;
                                else
                                    xfer_expected = xfer_expected + 16'd1;
                            end
                        end else if (take && it.block_number == prev_block) begin
                            // duplicate of the last block: ack again, no write
                            r.ack_valid     = 1'b1;
                            r.ack_block     = it.block_number;
                            r.ack_dest_ip   = it.source_ip;
                            r.ack_dest_port = xfer_peer_port;
                        end
                    end
                end
            end
            default: ;
        endcase
        r.status         = xfer_phase;
        r.local_port     = xfer_port;
        r.bytes_received = xfer_total;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // scoreboard
    // ------------------------------------------------------------------

    task automatic show_field(input string label, input logic [31:0] want,
                              input logic [31:0] got);
        if (want !== got)
            $display("  %s: expected %0h, got %0h", label, want, got);
    endtask

    task automatic check_result(input rx_result_t want, input rx_result_t got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
                $display("mismatch on result beat %0d at %0t", results_seen, $realtime);
                show_field("status", 32'(want.status), 32'(got.status));
                show_field("ack_valid", 32'(want.ack_valid), 32'(got.ack_valid));
                show_field("ack_block", 32'(want.ack_block), 32'(got.ack_block));
                show_field("ack_dest_ip", want.ack_dest_ip, got.ack_dest_ip);
                show_field("ack_dest_port", 32'(want.ack_dest_port), 32'(got.ack_dest_port));
                show_field("local_port", 32'(want.local_port), 32'(got.local_port));
                show_field("write_valid", 32'(want.write_valid), 32'(got.write_valid));
                show_field("write_offset", 32'(want.write_offset), 32'(got.write_offset));
                show_field("write_length", 32'(want.write_length), 32'(got.write_length));
                show_field("bytes_received", 32'(want.bytes_received),
                           32'(got.bytes_received));
            end
        end
    endtask

    // result beats are checked before the input beat of the same edge is predicted
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (pending_results.size() == 0) begin
                    strays++;
                    if (mismatches + strays <= MAX_REPORTS)
                        $display("result beat with nothing expected at %0t", $realtime);
                end else begin
                    check_result(pending_results.pop_front(), observed);
                end
            end
            if (s_valid && s_ready)
                pending_results.push_back(next_transfer_result(offered));
        end
    end

    // receiver stalls
    always @(posedge aclk)
        m_ready <= ($urandom_range(99) >= recv_idle_pct);

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------

    function automatic pkt_item_t make_item(input logic [1:0] cmd, input logic [15:0] op,
                                            input logic [15:0] blk, input logic [31:0] ip,
                                            input logic [15:0] port, input logic [9:0] len);
        return {cmd, op, blk, ip, port, len};
    endfunction

    // one input beat; valid stays high into the next call unless a gap is drawn
    task automatic send_item(input pkt_item_t it);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid         <= 1'b1;
        s_cmd           <= it.cmd;
        s_opcode        <= it.opcode;
        s_block_number  <= it.block_number;
        s_source_ip     <= it.source_ip;
        s_source_port   <= it.source_port;
        s_packet_length <= it.packet_length;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    // start and tick carry random junk in the unused fields
    task automatic send_start();
        send_item(make_item(CMD_START, 16'($urandom), 16'($urandom), $urandom,
                            16'($urandom), 10'($urandom_range(600))));
    endtask

    task automatic send_tick();
        send_item(make_item(CMD_TICK, 16'($urandom), 16'($urandom), $urandom,
                            16'($urandom), 10'($urandom_range(600))));
    endtask

    task automatic send_data(input logic [15:0] blk, input logic [31:0] ip,
                             input logic [15:0] port, input logic [9:0] len);
        send_item(make_item(CMD_PACKET, OPCODE_DATA, blk, ip, port, len));
    endtask

    // hold off until every expected beat is back, then let the pipe settle
    task automatic wait_drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (results_seen < items_sent)
            @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    // register write, only called with the block idle
    task automatic write_reg(input logic [0:0] idx, input logic [23:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        if (idx == REG_BUFFER_LIMIT)
            cfg_buffer_limit = value;
        else
            cfg_timeout = value[15:0];
    endtask

    // upper bits of the timeout write are junk and must be dropped
    task automatic set_config(input logic [23:0] limit, input logic [15:0] ticks);
        write_reg(REG_BUFFER_LIMIT, limit);
        write_reg(REG_TIMEOUT_TICKS, {8'($urandom), ticks});
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // hand-picked beats: every command and opcode class, field extremes
    task automatic test_directed();
        send_tick();                                            // idle: no effect
        send_data(16'd1, PEER_IP, PEER_PORT, FULL_PACKET);      // idle: no effect
        send_item(make_item(CMD_UNUSED, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF,
                            10'd600));
        send_start();
        send_data(16'd1, PEER_IP, PEER_PORT, HEADER_BYTES - 10'd1);  // too short
        send_item(make_item(CMD_PACKET, OPCODE_ACK, 16'd1, PEER_IP, PEER_PORT,
                            HEADER_BYTES));
        send_item(make_item(CMD_PACKET, 16'hFFFF, 16'd1, PEER_IP, PEER_PORT, 10'd600));
        // block zero locks the port and is acked as the previous block
        send_data(16'd0, 32'hFFFF_FFFF, 16'hFFFF, FULL_PACKET);
        send_data(16'd1, PEER_IP, PEER_PORT, FULL_PACKET);      // wrong port
        send_data(16'd1, PEER_IP, 16'hFFFF, FULL_PACKET);
        send_data(16'd1, PEER_IP, 16'hFFFF, FULL_PACKET);       // duplicate
        send_data(16'd3, PEER_IP, 16'hFFFF, FULL_PACKET);       // out of order
        send_data(16'd2, PEER_IP, 16'hFFFF, 10'd600);           // oversized payload
        send_tick();
        send_item(make_item(CMD_PACKET, OPCODE_ERROR, 16'd0, 32'd0, 16'd0, HEADER_BYTES));
        send_data(16'd3, PEER_IP, 16'hFFFF, FULL_PACKET);       // after error
        send_start();
        send_data(16'd1, 32'd0, 16'd0, HEADER_BYTES);           // empty last block
        send_start();
        send_data(16'd5, PEER_IP, 16'd7, FULL_PACKET);          // locks, block dropped
        send_data(16'd1, PEER_IP, 16'd8, FULL_PACKET);
        send_data(16'd1, PEER_IP, 16'd7, FULL_PACKET - 10'd1);
        send_start();
        send_data(16'hFFFF, PEER_IP, PEER_PORT, FULL_PACKET);
        send_start();                                           // restart while busy
        wait_drain();
    endtask

    // reset value of the buffer limit, filled exactly with oversized blocks,
    // then one more byte overflows; the remainder is still a full-size block
    task automatic test_default_limits();
        int n_full;
        int rest;
        n_full = int'(BUFFER_LIMIT_RST) / MAX_PAYLOAD;
        rest   = int'(BUFFER_LIMIT_RST) - n_full * MAX_PAYLOAD;
        send_start();
        for (int b = 1; b <= n_full; b++)
            send_data(16'(b), PEER_IP, PEER_PORT, 10'(MAX_PAYLOAD) + HEADER_BYTES);
        send_data(16'(n_full + 1), PEER_IP, PEER_PORT, 10'(rest) + HEADER_BYTES);
        send_data(16'(n_full + 2), PEER_IP, PEER_PORT, HEADER_BYTES + 10'd1);
        wait_drain();
    endtask

    task automatic test_config_extremes();
        // zero buffer and zero ticks
        set_config(24'd0, 16'd0);
        send_start();
        send_tick();
        send_start();
        send_data(16'd1, PEER_IP, PEER_PORT, HEADER_BYTES);
        send_start();
        send_data(16'd1, PEER_IP, PEER_PORT, HEADER_BYTES + 10'd1);
        wait_drain();
        // everything at its maximum
        set_config(24'hFF_FFFF, 16'hFFFF);
        send_start();
        for (int b = 1; b <= 4; b++)
            send_data(16'(b), $urandom, PEER_PORT, FULL_PACKET);
        send_tick();
        send_data(16'd5, $urandom, PEER_PORT, 10'd100);
        wait_drain();
        // two blocks fill the buffer exactly, the third overflows
        set_config(24'd1024, 16'd50);
        send_start();
        send_data(16'd1, PEER_IP, PEER_PORT, FULL_PACKET);
        send_data(16'd2, PEER_IP, PEER_PORT, FULL_PACKET);
        send_data(16'd3, PEER_IP, PEER_PORT, FULL_PACKET);
        send_data(16'd2, PEER_IP, PEER_PORT, FULL_PACKET);
        wait_drain();
    endtask

    task automatic test_timeout_small();
        set_config(24'd65536, 16'd3);
        send_start();
        repeat (3) send_tick();
        send_data(16'd1, PEER_IP, PEER_PORT, FULL_PACKET);
        send_tick();                                            // deadline passed
        send_tick();
        send_start();
        send_data(16'd1, PEER_IP, PEER_PORT, 10'd20);
        send_tick();                                            // done: ignored
        wait_drain();
    endtask

    // mostly well-formed transfers with random content, some noise and damage
    task automatic run_random_transfers(input int n_items);
        int          done_items;
        int          n_blocks;
        int          pick;
        logic [15:0] blk;
        logic [15:0] srv_port;
        logic [31:0] srv_ip;
        logic [9:0]  len;
        done_items = 0;
        while (done_items < n_items) begin
            if ($urandom_range(99) < 15) begin
                send_item(make_item(2'($urandom), 16'($urandom), 16'($urandom), $urandom,
                                    16'($urandom), 10'($urandom_range(600))));
                done_items++;
            end else begin
                srv_ip   = $urandom;
                srv_port = 16'($urandom);
                blk      = 16'd1;
                send_start();
                done_items++;
                n_blocks = $urandom_range(1, 12);
                repeat (n_blocks) begin
                    pick = $urandom_range(99);
                    len  = ($urandom_range(9) == 0) ?
                           10'($urandom_range(int'(FULL_PACKET) + 1, 600)) : FULL_PACKET;
                    if (pick < 60) begin
                        send_data(blk, srv_ip, srv_port, len);
                        blk = blk + 16'd1;
                    end else if (pick < 68) begin
                        send_data(blk - 16'd1, srv_ip, srv_port, len);
                    end else if (pick < 74) begin
                        send_data(blk, srv_ip, 16'($urandom), len);
                    end else if (pick < 82) begin
                        send_tick();
                    end else if (pick < 86) begin
                        send_data(blk, srv_ip, srv_port, 10'($urandom_range(3)));
                    end else if (pick < 89) begin
                        send_item(make_item(CMD_PACKET, OPCODE_ERROR, 16'($urandom), srv_ip,
                                            srv_port, 10'($urandom_range(4, 600))));
                    end else if (pick < 93) begin
                        send_data(16'($urandom), srv_ip, srv_port, len);
                    end else begin
                        send_item(make_item(CMD_PACKET, OPCODE_ACK, blk, srv_ip, srv_port,
                                            len));
                    end
                    done_items++;
                end
                // usually finish with a short block
                if ($urandom_range(99) < 80) begin
                    send_data(blk, srv_ip, srv_port,
                              10'($urandom_range(4, int'(FULL_PACKET) - 1)));
                    done_items++;
                end
            end
        end
    endtask

    // chunks of random traffic, each under a fresh register setting
    task automatic test_random_traffic(input int n_chunks, input int chunk_items);
        logic [23:0] limit;
        logic [15:0] ticks;
        repeat (n_chunks) begin
            wait_drain();
            case ($urandom_range(3))
                0:       limit = 24'($urandom_range(3000));
                1, 2:    limit = 24'($urandom_range(3000, 40000));
                default: limit = 24'($urandom);
            endcase
            if ($urandom_range(9) < 3)
                ticks = 16'($urandom_range(8));
            else
                ticks = 16'($urandom_range(100, 65535));
            set_config(limit, ticks);
            run_random_transfers(chunk_items);
        end
        wait_drain();
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------

    initial begin
        model_reset();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // sender idles less than receiver
        send_idle_pct = 36;
        recv_idle_pct = 47;
        test_directed();
        test_default_limits();
        test_config_extremes();
        test_random_traffic(2, 45);

        // the other way round
        send_idle_pct = 47;
        recv_idle_pct = 36;
        test_timeout_small();
        test_random_traffic(2, 45);

        // back to back
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(2, 45);

        wait_drain();
        if (mismatches == 0 && strays == 0 && pending_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
